// ----- design/itk_pkg.sv -----
// Shared types, codes and character helpers of the IDL source tokenizer.
// No dependencies; every other file imports this package.
package itk_pkg;

    localparam int POS_W  = 24;
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [7:0] BOM_B0 = 8'hEF;
    localparam logic [7:0] BOM_B1 = 8'hBB;
    localparam logic [7:0] BOM_B2 = 8'hBF;

    // scanner modes
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_IDENT = 3'd1;
    localparam logic [2:0] MODE_NUM   = 3'd2;
    localparam logic [2:0] MODE_STR   = 3'd3;
    localparam logic [2:0] MODE_CMT   = 3'd4;
    localparam logic [2:0] MODE_ARROW = 3'd5;

    // byte-order-mark stages
    localparam logic [1:0] BOM_UNDEC = 2'd0;
    localparam logic [1:0] BOM_SKIP1 = 2'd1;
    localparam logic [1:0] BOM_SKIP2 = 2'd2;
    localparam logic [1:0] BOM_DONE  = 2'd3;

    // record types
    localparam logic [1:0] RT_TOKEN = 2'd0;
    localparam logic [1:0] RT_UNTERM = 2'd1;
    localparam logic [1:0] RT_BADCH = 2'd2;

    // token kinds
    localparam logic [3:0] KIND_END    = 4'd0;
    localparam logic [3:0] KIND_IDENT  = 4'd1;
    localparam logic [3:0] KIND_NUMBER = 4'd2;
    localparam logic [3:0] KIND_STRING = 4'd3;
    localparam logic [3:0] KIND_SEMI   = 4'd4;
    localparam logic [3:0] KIND_COMMA  = 4'd5;
    localparam logic [3:0] KIND_DOT    = 4'd6;
    localparam logic [3:0] KIND_ARROW  = 4'd7;
    localparam logic [3:0] KIND_EQ     = 4'd8;
    localparam logic [3:0] KIND_AT     = 4'd9;
    localparam logic [3:0] KIND_LBRACE = 4'd10;
    localparam logic [3:0] KIND_RBRACE = 4'd11;
    localparam logic [3:0] KIND_LPAREN = 4'd12;
    localparam logic [3:0] KIND_RPAREN = 4'd13;
    localparam logic [3:0] KIND_LT     = 4'd14;
    localparam logic [3:0] KIND_GT     = 4'd15;

    // queue commands
    localparam logic OP_SCAN  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic       op;
        logic       final_cmd;   // last command of its input word
        logic [7:0] c;
        logic [7:0] n1;
        logic [7:0] n2;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       rtype;
        logic [3:0]       kind;
        logic [7:0]       bad;
        logic [POS_W-1:0] off;
        logic [POS_W-1:0] len;
        logic [POS_W-1:0] line;
        logic [POS_W-1:0] col;
        logic             last;
    } t_rec;

    typedef struct packed {
        logic [POS_W-1:0] off;
        logic [POS_W-1:0] line;
        logic [POS_W-1:0] col;
    } t_pos;

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] x);
        return (x == POS_MAX) ? x : x + POS_W'(1);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_ident_start(input logic [7:0] c);
        return is_alpha(c) || c == "_";
    endfunction

    function automatic logic is_ident_body(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
    endfunction

    function automatic logic [3:0] punct_kind(input logic [7:0] c);
        logic [3:0] k;
        unique case (c)
            ";":     k = KIND_SEMI;
            ",":     k = KIND_COMMA;
            ".":     k = KIND_DOT;
            "=":     k = KIND_EQ;
            "@":     k = KIND_AT;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "<":     k = KIND_LT;
            ">":     k = KIND_GT;
            default: k = KIND_END;
        endcase
        return k;
    endfunction

endpackage

// ----- design/itk_if.sv -----
// Channel interfaces of the tokenizer: source-byte words in, record words out.
// Depends on itk_pkg.
interface itk_in_if;
    import itk_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       has_byte;
    logic       end_of_source;
    modport source (output valid, source_byte, has_byte, end_of_source, input ready);
    modport sink   (input valid, source_byte, has_byte, end_of_source, output ready);
endinterface

interface itk_out_if;
    import itk_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       record_type;
    logic [3:0]       token_kind;
    logic [7:0]       bad_char;
    logic [POS_W-1:0] start_offset;
    logic [POS_W-1:0] token_length;
    logic [POS_W-1:0] line_number;
    logic [POS_W-1:0] column_number;
    logic             last_of_run;
    modport source (output valid, record_type, token_kind, bad_char, start_offset,
                    token_length, line_number, column_number, last_of_run, input ready);
    modport sink   (input valid, record_type, token_kind, bad_char, start_offset,
                    token_length, line_number, column_number, last_of_run, output ready);
endinterface

// ----- design/itk_front.sv -----
// Front end: input handshake and two-byte lookahead, turns words into scan and flush commands.
// Depends on itk_pkg and itk_in_if.
module itk_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    itk_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output itk_pkg::t_cmd o_cmd
);
    import itk_pkg::*;

    logic [7:0] r_la0, r_la1, n_la0, n_la1;
    logic [1:0] r_cnt, n_cnt;
    logic       r_pend, n_pend;   // end of source being drained

    assign i_in.ready = !r_pend && !i_q_full;

    always_comb begin
        n_la0  = r_la0;
        n_la1  = r_la1;
        n_cnt  = r_cnt;
        n_pend = r_pend;
        o_push = 1'b0;
        o_cmd  = '0;
        if (r_pend) begin
            if (!i_q_full) begin
                o_push = 1'b1;
                if (r_cnt == 2'd2) begin
                    o_cmd = '{op: OP_SCAN, final_cmd: 1'b0, c: r_la0, n1: r_la1, n2: 8'h00};
                    n_la0 = r_la1;
                    n_cnt = 2'd1;
                end else if (r_cnt == 2'd1) begin
                    o_cmd = '{op: OP_SCAN, final_cmd: 1'b0, c: r_la0, n1: 8'h00, n2: 8'h00};
                    n_cnt = 2'd0;
                end else begin
                    o_cmd  = '{op: OP_FLUSH, final_cmd: 1'b1, c: 8'h00, n1: 8'h00, n2: 8'h00};
                    n_pend = 1'b0;
                    n_la0  = 8'h00;
                    n_la1  = 8'h00;
                end
            end
        end else if (i_in.valid && i_in.ready) begin
            if (i_in.has_byte) begin
                if (r_cnt == 2'd2) begin
                    o_push = 1'b1;
                    o_cmd  = '{op: OP_SCAN, final_cmd: !i_in.end_of_source, c: r_la0,
                               n1: r_la1, n2: i_in.source_byte};
                    n_la0  = r_la1;
                    n_la1  = i_in.source_byte;
                end else if (r_cnt == 2'd1) begin
                    n_la1 = i_in.source_byte;
                    n_cnt = 2'd2;
                end else begin
                    n_la0 = i_in.source_byte;
                    n_cnt = 2'd1;
                end
            end
            if (i_in.end_of_source) n_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_la0  <= 8'h00;
            r_la1  <= 8'h00;
            r_cnt  <= 2'd0;
            r_pend <= 1'b0;
        end else begin
            r_la0  <= n_la0;
            r_la1  <= n_la1;
            r_cnt  <= n_cnt;
            r_pend <= n_pend;
        end
    end
endmodule

// ----- design/itk_queue.sv -----
// Short command queue between the front end and the scanner.
// Depends on itk_pkg.
module itk_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  itk_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output itk_pkg::t_cmd o_cmd
);
    import itk_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QAW'(1);
            if (i_pop)  r_rd <= r_rd + QAW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + (QAW+1)'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - (QAW+1)'(1);
        end
    end
endmodule

// ----- design/itk_back.sv -----
// Back end: scanner state machine, record builder and output register.
// Depends on itk_pkg and itk_out_if.
module itk_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  itk_pkg::t_cmd i_cmd,
    output logic          o_pop,
    itk_out_if.source     o_out
);
    import itk_pkg::*;

    // scanner state
    logic [2:0]       r_mode;
    logic [7:0]       r_prev;
    logic             r_esc;
    logic [1:0]       r_bom;
    logic [POS_W-1:0] r_ts, r_tl, r_tc;
    t_pos             r_pos;

    // output register plus up to two queued extra records
    logic             r_ov;
    t_rec             r_out;
    t_rec             r_pend [2];
    logic [1:0]       r_pn;

    logic [2:0]       v_mode;
    logic [7:0]       v_prev;
    logic             v_esc;
    logic [1:0]       v_bom;
    logic [POS_W-1:0] v_ts, v_tl, v_tc;
    t_pos             v_pos;
    t_rec             v_rec [3];
    logic [1:0]       v_n;
    logic             v_run, v_go;
    logic [3:0]       v_k;
    logic [7:0]       c, n1, n2;

    logic out_free;

    function automatic t_rec mk(input logic [1:0] rt, input logic [3:0] k,
                                input logic [7:0] bad, input logic [POS_W-1:0] off,
                                input logic [POS_W-1:0] len, input logic [POS_W-1:0] ln,
                                input logic [POS_W-1:0] cl);
        return '{rtype: rt, kind: k, bad: bad, off: off, len: len, line: ln, col: cl,
                 last: 1'b0};
    endfunction

    function automatic t_pos adv(input t_pos p, input logic [7:0] ch);
        t_pos q;
        q = p;
        if (ch == 8'h0A) begin
            q.line = sat_inc(p.line);
            q.col  = POS_W'(1);
        end else begin
            q.col = sat_inc(p.col);
        end
        q.off = sat_inc(p.off);
        return q;
    endfunction

    always_comb begin
        v_mode = r_mode;
        v_prev = r_prev;
        v_esc  = r_esc;
        v_bom  = r_bom;
        v_ts   = r_ts;
        v_tl   = r_tl;
        v_tc   = r_tc;
        v_pos  = r_pos;
        v_rec  = '{default: '0};
        v_n    = 2'd0;
        v_run  = 1'b0;
        v_go   = 1'b0;
        v_k    = KIND_END;
        c      = i_cmd.c;
        n1     = i_cmd.n1;
        n2     = i_cmd.n2;
        if (i_cmd.op == OP_SCAN) begin
            v_prev = c;
            if (r_bom == BOM_UNDEC) begin
                if (c == BOM_B0 && n1 == BOM_B1 && n2 == BOM_B2) begin
                    v_bom     = BOM_SKIP2;
                    v_pos.off = sat_inc(r_pos.off);
                end else begin
                    v_bom = BOM_DONE;
                    v_run = 1'b1;
                end
            end else if (r_bom != BOM_DONE) begin
                // rest of the mark moves the offset only
                v_bom     = (r_bom == BOM_SKIP2) ? BOM_SKIP1 : BOM_DONE;
                v_pos.off = sat_inc(r_pos.off);
            end else begin
                v_run = 1'b1;
            end

            if (v_run) begin
                unique case (r_mode)
                    MODE_CMT: begin
                        if (c != 8'h0A) v_pos = adv(v_pos, c);
                        else            v_go  = 1'b1;
                    end
                    MODE_ARROW: begin
                        v_mode = MODE_IDLE;
                        v_pos  = adv(v_pos, c);
                    end
                    MODE_IDENT: begin
                        if (is_ident_body(c)) begin
                            v_pos = adv(v_pos, c);
                        end else begin
                            v_rec[v_n] = mk(RT_TOKEN, KIND_IDENT, 8'h00, v_ts,
                                            v_pos.off - v_ts, v_tl, v_tc);
                            v_n  = v_n + 2'd1;
                            v_go = 1'b1;
                        end
                    end
                    MODE_NUM: begin
                        if (is_ident_body(c) || c == "." ||
                            ((c == "+" || c == "-") &&
                             (r_prev == "e" || r_prev == "E" ||
                              r_prev == "p" || r_prev == "P"))) begin
                            v_pos = adv(v_pos, c);
                        end else begin
                            v_rec[v_n] = mk(RT_TOKEN, KIND_NUMBER, 8'h00, v_ts,
                                            v_pos.off - v_ts, v_tl, v_tc);
                            v_n  = v_n + 2'd1;
                            v_go = 1'b1;
                        end
                    end
                    MODE_STR: begin
                        if (r_esc) begin
                            v_esc = 1'b0;
                            v_pos = adv(v_pos, c);
                        end else if (c == "\\" && (n1 == "\"" || n1 == "\\")) begin
                            v_esc = 1'b1;
                            v_pos = adv(v_pos, c);
                        end else if (c == "\"") begin
                            v_pos      = adv(v_pos, c);
                            v_rec[v_n] = mk(RT_TOKEN, KIND_STRING, 8'h00, v_ts,
                                            v_pos.off - v_ts, v_tl, v_tc);
                            v_n        = v_n + 2'd1;
                            v_mode     = MODE_IDLE;
                        end else if (c != 8'h0A) begin
                            v_pos = adv(v_pos, c);
                        end else begin
                            // newline ends an unterminated string: error first
                            v_rec[v_n] = mk(RT_UNTERM, KIND_END, 8'h00, v_ts, '0, v_tl, v_tc);
                            v_n        = v_n + 2'd1;
                            v_rec[v_n] = mk(RT_TOKEN, KIND_STRING, 8'h00, v_ts,
                                            v_pos.off - v_ts, v_tl, v_tc);
                            v_n        = v_n + 2'd1;
                            v_go       = 1'b1;
                        end
                    end
                    default: v_go = 1'b1;
                endcase
            end

            if (v_go) begin
                v_mode = MODE_IDLE;
                if (is_space(c)) begin
                    v_pos = adv(v_pos, c);
                end else if (c == "/" && n1 == "/") begin
                    v_mode = MODE_CMT;
                    v_pos  = adv(v_pos, c);
                end else begin
                    v_ts = v_pos.off;
                    v_tl = v_pos.line;
                    v_tc = v_pos.col;
                    if (is_ident_start(c)) begin
                        v_mode = MODE_IDENT;
                        v_pos  = adv(v_pos, c);
                    end else if (is_digit(c) || (c == "." && is_digit(n1)) ||
                                 ((c == "-" || c == "+") &&
                                  (is_digit(n1) || (n1 == "." && is_digit(n2))))) begin
                        v_mode = MODE_NUM;
                        v_pos  = adv(v_pos, c);
                    end else if (c == "\"") begin
                        v_mode = MODE_STR;
                        v_esc  = 1'b0;
                        v_pos  = adv(v_pos, c);
                    end else if (c == "-" && n1 == ">") begin
                        v_rec[v_n] = mk(RT_TOKEN, KIND_ARROW, 8'h00, v_ts, POS_W'(2),
                                        v_tl, v_tc);
                        v_n        = v_n + 2'd1;
                        v_mode     = MODE_ARROW;
                        v_pos      = adv(v_pos, c);
                    end else begin
                        v_k   = punct_kind(c);
                        v_pos = adv(v_pos, c);
                        if (v_k != KIND_END)
                            v_rec[v_n] = mk(RT_TOKEN, v_k, 8'h00, v_ts, v_pos.off - v_ts,
                                            v_tl, v_tc);
                        else
                            v_rec[v_n] = mk(RT_BADCH, KIND_END, c, v_ts, '0, v_tl, v_tc);
                        v_n = v_n + 2'd1;
                    end
                end
            end

            if (i_cmd.final_cmd && v_n != 2'd0) v_rec[v_n - 2'd1].last = 1'b1;
        end else begin
            // flush: close the open token, then End, then back to reset state
            if (r_mode == MODE_IDENT || r_mode == MODE_NUM) begin
                v_rec[v_n] = mk(RT_TOKEN, (r_mode == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER,
                                8'h00, r_ts, r_pos.off - r_ts, r_tl, r_tc);
                v_n        = v_n + 2'd1;
            end else if (r_mode == MODE_STR) begin
                v_rec[v_n] = mk(RT_UNTERM, KIND_END, 8'h00, r_ts, '0, r_tl, r_tc);
                v_n        = v_n + 2'd1;
                v_rec[v_n] = mk(RT_TOKEN, KIND_STRING, 8'h00, r_ts, r_pos.off - r_ts,
                                r_tl, r_tc);
                v_n        = v_n + 2'd1;
            end
            v_rec[v_n]      = mk(RT_TOKEN, KIND_END, 8'h00, r_pos.off, '0, r_pos.line,
                                 r_pos.col);
            v_rec[v_n].last = 1'b1;
            v_n             = v_n + 2'd1;
            v_mode          = MODE_IDLE;
            v_prev          = 8'h00;
            v_esc           = 1'b0;
            v_bom           = BOM_UNDEC;
            v_ts            = '0;
            v_tl            = POS_W'(1);
            v_tc            = POS_W'(1);
            v_pos           = '{off: '0, line: POS_W'(1), col: POS_W'(1)};
        end
    end

    assign out_free = !r_ov || o_out.ready;
    assign o_pop    = out_free && (r_pn == 2'd0) && i_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_pn   <= 2'd0;
            r_mode <= MODE_IDLE;
            r_prev <= 8'h00;
            r_esc  <= 1'b0;
            r_bom  <= BOM_UNDEC;
            r_ts   <= '0;
            r_tl   <= POS_W'(1);
            r_tc   <= POS_W'(1);
            r_pos  <= '{off: '0, line: POS_W'(1), col: POS_W'(1)};
        end else if (out_free && r_pn != 2'd0) begin
            r_ov      <= 1'b1;
            r_out     <= r_pend[0];
            r_pend[0] <= r_pend[1];
            r_pn      <= r_pn - 2'd1;
        end else if (o_pop) begin
            r_ov      <= (v_n != 2'd0);
            r_out     <= v_rec[0];
            r_pend[0] <= v_rec[1];
            r_pend[1] <= v_rec[2];
            r_pn      <= (v_n != 2'd0) ? v_n - 2'd1 : 2'd0;
            r_mode    <= v_mode;
            r_prev    <= v_prev;
            r_esc     <= v_esc;
            r_bom     <= v_bom;
            r_ts      <= v_ts;
            r_tl      <= v_tl;
            r_tc      <= v_tc;
            r_pos     <= v_pos;
        end else if (out_free) begin
            r_ov <= 1'b0;
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.record_type   = r_out.rtype;
    assign o_out.token_kind    = r_out.kind;
    assign o_out.bad_char      = r_out.bad;
    assign o_out.start_offset  = r_out.off;
    assign o_out.token_length  = r_out.len;
    assign o_out.line_number   = r_out.line;
    assign o_out.column_number = r_out.col;
    assign o_out.last_of_run   = r_out.last;
endmodule

// ----- design/idl_source_tokenizer_unit.sv -----
// Streaming IDL tokenizer. Takes one source byte per word and sustains one word
// per cycle while the command queue has room; an end-of-source word holds the input
// while the front end drains its buffered lookahead bytes (up to two) and then issues
// the flush. Records leave one per cycle from the scanner's output register while the
// sink is ready; a byte that closes one token and opens another gives two records and a
// flush up to three, and the extra records hold the command queue while they leave, which
// the four-entry queue absorbs. Offsets, lines and columns saturate at all ones. After End the
// block is back in its reset state and the next byte starts a new source.
// Depends on itk_pkg, itk_if, itk_front, itk_queue and itk_back.
module idl_source_tokenizer_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itk_in_if.sink    i_in,
    itk_out_if.source o_out
);
    import itk_pkg::*;

    // front end -> queue
    logic w_push, w_full;
    t_cmd w_cmd_in;
    // queue -> scanner
    logic w_pop, w_qvalid;
    t_cmd w_cmd_out;

    itk_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_cmd    (w_cmd_in)
    );

    itk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_cmd   (w_cmd_out)
    );

    itk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_qvalid),
        .i_cmd       (w_cmd_out),
        .o_pop       (w_pop),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qvalid)
        else $error("command popped from empty queue");

    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.record_type != RT_TOKEN) |-> (o_out.token_kind == KIND_END))
        else $error("error record carries a token kind");
`endif
endmodule
